FILE: sv/eiep_pkg.sv
// ----------------------------------------------------------------------------
// EBML integer element parser package
// Beat types, status codes and vint helper functions.
// ----------------------------------------------------------------------------
package eiep_pkg;

  localparam int unsigned MaxVintOctets = 8;

  localparam logic [1:0] StOk          = 2'd0;
  localparam logic [1:0] StIdMismatch  = 2'd1;
  localparam logic [1:0] StVintLong    = 2'd2;
  localparam logic [1:0] StPayloadLong = 2'd3;

  localparam logic [1:0] CfgExpectedId = 2'd0;
  localparam logic [1:0] CfgMatchAny   = 2'd1;
  localparam logic [1:0] CfgSignedMode = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] element_id;
    logic [3:0]  payload_length;
    logic [63:0] element_value;
  } out_beat_t;

  // octet count of a vint from its first byte; 9 for a zero byte
  function automatic logic [3:0] vint_octets(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd9;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(8 - i);
    end
    return n;
  endfunction

  // (leading zeros mod 8) + 1; one octet for a zero id
  function automatic logic [3:0] id_octets(input logic [31:0] id);
    logic [5:0] z;
    z = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (id[i]) z = 6'(31 - i);
    end
    return {1'b0, z[2:0]} + 4'd1;
  endfunction

endpackage

FILE: sv/ebml_integer_element_parser_unit.sv
// ----------------------------------------------------------------------------
// EBML integer element parser
// Parses EBML element headers byte by byte and returns integer payloads.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per beat (in_valid_i / in_stall_o), with a
// restart flag that drops a partial element. Output channel: one beat per
// element (out_valid_o / out_stall_i) with status, element ID, payload
// length and the 64-bit value, sign-extended when signed mode is set.
// Configuration: plain write port, index 0 expected ID, 1 match-any, 2 signed
// mode; the user must write it only while the block is idle (not enforced).
// Throughput: one byte per cycle. Each byte updates the header and payload
// accumulators in a single pass; the result lands in the output register.
// Latency: the result of an element's last byte is valid the next cycle.
// Stall: while the output register holds an untaken beat and out_stall_i
// is high, in_stall_o is raised; otherwise a byte is taken every cycle,
// including in the cycle the held beat leaves.
// Reset: parser waits for an ID first byte, expected ID 0, match-any on,
// signed mode off, output empty.
// ----------------------------------------------------------------------------
module ebml_integer_element_parser_unit import eiep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_beat_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_beat_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [1:0] PhId      = 2'd0;
  localparam logic [1:0] PhSize    = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;
  localparam logic [1:0] PhUnused  = 2'd3;

  logic [31:0] expected_id_q;
  logic [3:0]  exp_oct_q;
  logic        match_any_q, signed_mode_q;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  seen_q, seen_d;
  logic [3:0]  exp_q, exp_d;
  logic [31:0] id_q, id_d;
  logic [3:0]  len_lo_q, len_lo_d;
  logic        len_big_q, len_big_d;
  logic [3:0]  rem_q, rem_d;
  logic [63:0] val_q, val_d;

  logic        out_valid_q;
  out_beat_t   out_q;

  logic        in_acc, out_load;
  logic        emit;
  out_beat_t   res;

  logic [7:0]  b;
  logic        go_idle;
  logic [1:0]  ph;
  logic [3:0]  seen_e, exp_e, n_oct;
  logic [3:0]  seen_n, exp_n, lo_n;
  logic        big_n;
  logic [31:0] id_n;
  logic [7:0]  stripped;
  logic [63:0] v_n, v_ext;
  logic [3:0]  rem_n;
  logic        sgn;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_load   = ~out_valid_q | ~out_stall_i;

  assign b       = in_beat_i.data_byte;
  assign go_idle = in_beat_i.restart | (phase_q == PhUnused);
  assign ph      = go_idle ? PhId : phase_q;
  assign seen_e  = go_idle ? 4'd0 : seen_q;
  assign exp_e   = go_idle ? 4'd0 : exp_q;
  assign n_oct   = vint_octets(b);

  // sign extension of the payload from its byte length
  always_comb begin
    v_n = {val_q[55:0], b};
    sgn = 1'b0;
    for (int k = 1; k < 8; k++) begin
      if (len_lo_q == 4'(k)) sgn = v_n[8*k-1];
    end
    v_ext = v_n;
    for (int k = 0; k < 8; k++) begin
      if (signed_mode_q && sgn && (4'(k) >= len_lo_q)) v_ext[8*k +: 8] = 8'hFF;
    end
  end

  always_comb begin
    phase_d   = ph;
    seen_d    = seen_e;
    exp_d     = exp_e;
    id_d      = id_q;
    len_lo_d  = len_lo_q;
    len_big_d = len_big_q;
    rem_d     = rem_q;
    val_d     = val_q;
    emit      = 1'b0;
    res       = '{status: StOk, element_id: id_q, payload_length: 4'd0,
                  element_value: 64'd0};
    seen_n    = seen_e;
    exp_n     = exp_e;
    id_n      = id_q;
    lo_n      = len_lo_q;
    big_n     = len_big_q;
    stripped  = 8'd0;
    rem_n     = rem_q;

    case (ph)
      PhSize: begin
        if (seen_e == 4'd0) begin
          stripped = b & ~(8'h80 >> 3'(n_oct - 4'd1));
          lo_n     = stripped[3:0];
          big_n    = |stripped[7:4];
          exp_n    = n_oct;
          seen_n   = 4'd1;
        end else begin
          lo_n   = b[3:0];
          big_n  = len_big_q | (len_lo_q != 4'd0) | (|b[7:4]);
          seen_n = seen_e + 4'd1;
        end
        if (seen_e == 4'd0 && n_oct > 4'(MaxVintOctets)) begin
          emit       = 1'b1;
          res.status = StVintLong;
        end else begin
          len_lo_d  = lo_n;
          len_big_d = big_n;
          seen_d    = seen_n;
          exp_d     = exp_n;
          if (seen_n >= exp_n) begin
            seen_d = 4'd0;
            exp_d  = 4'd0;
            if (big_n || lo_n > 4'd8) begin
              emit       = 1'b1;
              res.status = StPayloadLong;
            end else if (lo_n == 4'd0) begin
              emit = 1'b1;
            end else begin
              rem_d   = lo_n;
              val_d   = 64'd0;
              phase_d = PhPayload;
            end
          end
        end
      end
      PhPayload: begin
        val_d = v_n;
        rem_n = (rem_q != 4'd0) ? rem_q - 4'd1 : rem_q;
        rem_d = rem_n;
        if (rem_n == 4'd0) begin
          emit                 = 1'b1;
          res.payload_length   = len_lo_q;
          res.element_value    = v_ext;
        end
      end
      default: begin
        if (seen_e == 4'd0) begin
          id_n   = {24'd0, b};
          exp_n  = n_oct;
          seen_n = 4'd1;
        end else begin
          id_n   = {id_q[23:0], b};
          seen_n = seen_e + 4'd1;
        end
        id_d           = id_n;
        res.element_id = id_n;
        if (seen_e == 4'd0 && n_oct > 4'(MaxVintOctets)) begin
          emit       = 1'b1;
          res.status = StVintLong;
        end else begin
          seen_d = seen_n;
          exp_d  = exp_n;
          if (seen_n >= exp_n) begin
            seen_d = 4'd0;
            exp_d  = 4'd0;
            if (!match_any_q && (exp_oct_q != exp_n || id_n != expected_id_q)) begin
              emit       = 1'b1;
              res.status = StIdMismatch;
            end else begin
              phase_d = PhSize;
            end
          end
        end
      end
    endcase

    if (emit) begin
      phase_d = PhId;
      seen_d  = 4'd0;
      exp_d   = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= 32'd0;
      exp_oct_q     <= 4'd1;
      match_any_q   <= 1'b1;
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgExpectedId: begin
          expected_id_q <= cfg_data_i;
          exp_oct_q     <= id_octets(cfg_data_i);
        end
        CfgMatchAny:   match_any_q   <= cfg_data_i[0];
        CfgSignedMode: signed_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhId;
      seen_q    <= 4'd0;
      exp_q     <= 4'd0;
      id_q      <= 32'd0;
      len_lo_q  <= 4'd0;
      len_big_q <= 1'b0;
      rem_q     <= 4'd0;
      val_q     <= 64'd0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      seen_q    <= seen_d;
      exp_q     <= exp_d;
      id_q      <= id_d;
      len_lo_q  <= len_lo_d;
      len_big_q <= len_big_d;
      rem_q     <= rem_d;
      val_q     <= val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_acc & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_acc && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

FILE: sv/eiep_checker.sv
// ----------------------------------------------------------------------------
// EBML integer element parser checker
// Port-level properties of the parser, bound into the parser module.
// ----------------------------------------------------------------------------
module eiep_checker import eiep_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_beat_t   out_beat_o
);

  // a held beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat changed while stalled");

  // input backpressure only comes from a held output beat
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output beat");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.status != StOk |->
      out_beat_o.payload_length == 4'd0 && out_beat_o.element_value == 64'd0)
    else $error("error beat carries a value");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.payload_length <= 4'd8)
    else $error("payload length above eight");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.payload_length == 4'd0 |->
      out_beat_o.element_value == 64'd0)
    else $error("empty payload with nonzero value");

endmodule

bind ebml_integer_element_parser_unit eiep_checker u_eiep_checker (.*);

FILE: bench/ebml_integer_element_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EBML integer element parser testbench
// Drives byte streams of well-formed, truncated and noisy elements through
// the parser under several register settings, with random gaps on both
// sides and one long output hold-off. Each element result is checked field
// by field against an in-bench parser.
// ----------------------------------------------------------------------------
module ebml_integer_element_parser_unit_test;
  import eiep_pkg::*;

  typedef enum logic [1:0] {SeekId, ReadSize, ReadPayload} parse_phase_e;

  localparam int QuietLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_stall_o;
  in_beat_t    in_beat_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_beat_t   out_beat_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  ebml_integer_element_parser_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_beat_t  stream_octets[$];
  out_beat_t results_due[$];
  int        send_idle_pct;
  int        recv_idle_pct;
  logic      reader_paused;
  bit        resync_next;
  int        error_count;
  int        quiet_cycles;

  // parser state
  logic [31:0]  cfg_expected_id;
  logic         cfg_match_any;
  logic         cfg_signed;
  parse_phase_e phase;
  logic [3:0]   seen;
  logic [3:0]   want;
  logic [31:0]  id_acc;
  logic [63:0]  len_acc;
  logic [3:0]   remain;
  logic [63:0]  val_acc;

  function automatic logic [3:0] vint_len(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) return 4'(8 - i);
    end
    return 4'd9;
  endfunction

  function automatic logic [3:0] id_len_of(input logic [31:0] id);
    int z;
    z = 0;
    while (z < 32 && !id[31 - z]) z++;
    return 4'((z % 8) + 1);
  endfunction

  function automatic out_beat_t close_element(input logic [1:0] st, input logic [3:0] len,
                                              input logic [63:0] val);
    out_beat_t r;
    r.status = st;
    r.element_id = id_acc;
    r.payload_length = len;
    r.element_value = val;
    phase = SeekId;
    seen = '0;
    want = '0;
    return r;
  endfunction

  function automatic bit parse_octet(input in_beat_t beat, output out_beat_t res);
    logic [3:0]  n;
    logic [63:0] v;
    int          len;
    res = '0;
    if (beat.restart) begin
      phase = SeekId;
      seen = '0;
      want = '0;
    end
    if (phase == ReadSize) begin
      if (seen == 0) begin
        n = vint_len(beat.data_byte);
        if (n > MaxVintOctets) begin
          res = close_element(StVintLong, 4'd0, 64'd0);
          return 1'b1;
        end
        len_acc = {56'd0, beat.data_byte};
        want = n;
        seen = 4'd1;
      end else begin
        len_acc = {len_acc[55:0], beat.data_byte};
        seen = seen + 4'd1;
      end
      if (seen >= want) begin
        len_acc[7 * want] = 1'b0;
        if (len_acc > 64'd8) begin
          res = close_element(StPayloadLong, 4'd0, 64'd0);
          return 1'b1;
        end
        if (len_acc == 64'd0) begin
          res = close_element(StOk, 4'd0, 64'd0);
          return 1'b1;
        end
        remain = len_acc[3:0];
        val_acc = '0;
        phase = ReadPayload;
        seen = '0;
        want = '0;
      end
      return 1'b0;
    end
    if (phase == ReadPayload) begin
      val_acc = {val_acc[55:0], beat.data_byte};
      if (remain != 0) remain = remain - 4'd1;
      if (remain == 0) begin
        len = int'(len_acc[3:0]);
        v = val_acc;
        if (cfg_signed && len >= 1 && len < 8 && v[8 * len - 1]) v = v | (~64'd0 << (8 * len));
        res = close_element(StOk, len_acc[3:0], v);
        return 1'b1;
      end
      return 1'b0;
    end
    // header ID
    if (seen == 0) begin
      n = vint_len(beat.data_byte);
      id_acc = {24'd0, beat.data_byte};
      if (n > MaxVintOctets) begin
        res = close_element(StVintLong, 4'd0, 64'd0);
        return 1'b1;
      end
      want = n;
      seen = 4'd1;
    end else begin
      id_acc = {id_acc[23:0], beat.data_byte};
      seen = seen + 4'd1;
    end
    if (seen >= want) begin
      if (!cfg_match_any && (id_len_of(cfg_expected_id) != want || id_acc != cfg_expected_id)) begin
        res = close_element(StIdMismatch, 4'd0, 64'd0);
        return 1'b1;
      end
      phase = ReadSize;
      seen = '0;
      want = '0;
    end
    return 1'b0;
  endfunction

  // ------------------------------------------------------------------------
  // stream building
  // ------------------------------------------------------------------------
  function automatic logic [63:0] vint_code(input int len, input logic [63:0] bits);
    return (bits & ((64'd1 << (7 * len)) - 64'd1)) | (64'd1 << (7 * len));
  endfunction

  task automatic push_octets(ref logic [7:0] q[$], input logic [63:0] word, input int len);
    for (int k = len - 1; k >= 0; k--) q.push_back(word[8 * k +: 8]);
  endtask

  task automatic push_beat(input logic [7:0] data, input logic restart);
    in_beat_t b;
    b.data_byte = data;
    b.restart = restart;
    stream_octets.push_back(b);
  endtask

  task automatic queue_element();
    logic [7:0]  octets[$];
    logic [63:0] size_bits;
    int          pick;
    int          id_len;
    int          size_len;
    int          pay_len;
    int          keep;
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      repeat ($urandom_range(1, 4)) begin
        push_beat(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), 1'($urandom));
      end
    end else begin
      if (!cfg_match_any && $urandom_range(0, 3) != 0) begin
        push_octets(octets, {32'd0, cfg_expected_id}, int'(id_len_of(cfg_expected_id)));
      end else begin
        id_len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        push_octets(octets, vint_code(id_len, {$urandom, $urandom}), id_len);
      end
      size_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 1;
      if ($urandom_range(0, 9) == 0) begin
        size_bits = ($urandom_range(0, 3) == 0) ? ~64'd0 : {$urandom, $urandom};
        size_bits = size_bits & ((64'd1 << (7 * size_len)) - 64'd1);
        if (size_bits <= 64'd8) size_bits = size_bits | 64'd9;
        pay_len = 0;
      end else begin
        pay_len = $urandom_range(0, 8);
        size_bits = 64'(pay_len);
      end
      push_octets(octets, vint_code(size_len, size_bits), size_len);
      repeat (pay_len) octets.push_back(8'($urandom));
      if (pick >= 80 && octets.size() > 1) begin
        keep = $urandom_range(1, octets.size() - 1);
        while (octets.size() > keep) void'(octets.pop_back());
      end
      foreach (octets[i]) begin
        push_beat(octets[i], (i == 0) && (resync_next || $urandom_range(0, 7) == 0));
      end
    end
    resync_next = (pick >= 80) && ($urandom_range(0, 3) != 0);
  endtask

  task automatic queue_stream(input int count);
    while (stream_octets.size() < count) queue_element();
  endtask

  // ------------------------------------------------------------------------
  // driver, monitor, watchdog
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_octets
    out_beat_t res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (parse_octet(in_beat_i, res)) results_due.push_back(res);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (stream_octets.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_beat_i <= stream_octets.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    out_beat_t exp_beat;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected beat: status %0d id %h len %0d value %h", out_beat_o.status,
                     out_beat_o.element_id, out_beat_o.payload_length, out_beat_o.element_value);
        end else begin
          exp_beat = results_due.pop_front();
          if (out_beat_o.status !== exp_beat.status ||
              out_beat_o.element_id !== exp_beat.element_id ||
              out_beat_o.payload_length !== exp_beat.payload_length ||
              out_beat_o.element_value !== exp_beat.element_value) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch exp/got: status %0d/%0d id %h/%h len %0d/%0d value %h/%h",
                       exp_beat.status, out_beat_o.status,
                       exp_beat.element_id, out_beat_o.element_id,
                       exp_beat.payload_length, out_beat_o.payload_length,
                       exp_beat.element_value, out_beat_o.element_value);
          end
        end
      end
      out_stall_i <= reader_paused || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("** ebml_integer_element_parser_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // sequencing
  // ------------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgExpectedId: cfg_expected_id = data;
      CfgMatchAny:   cfg_match_any = data[0];
      CfgSignedMode: cfg_signed = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] id, input logic any, input logic sgn);
    write_reg(CfgExpectedId, id);
    write_reg(CfgMatchAny, {31'd0, any});
    write_reg(CfgSignedMode, {31'd0, sgn});
  endtask

  task automatic wait_drained();
    while (stream_octets.size() != 0 || in_valid_i || results_due.size() != 0)
      @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // a zero byte with restart always closes the element, leaving the parser idle
  task automatic close_phase();
    push_beat(8'h00, 1'b1);
    resync_next = 1'b0;
    wait_drained();
  endtask

  initial begin
    in_valid_i = 1'b0;
    in_beat_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgExpectedId;
    cfg_data_i = '0;
    reader_paused = 1'b0;
    resync_next = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 33;
    recv_idle_pct = 55;
    cfg_expected_id = '0;
    cfg_match_any = 1'b1;
    cfg_signed = 1'b0;
    phase = SeekId;
    seen = '0;
    want = '0;
    id_acc = '0;
    len_acc = '0;
    remain = '0;
    val_acc = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed elements
    configure(32'h0000_4286, 1'b0, 1'b1);
    push_beat(8'h42, 1'b0); push_beat(8'h86, 1'b0); push_beat(8'h81, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h42, 1'b0); push_beat(8'h86, 1'b0); push_beat(8'h00, 1'b0);
    push_beat(8'h42, 1'b0); push_beat(8'h86, 1'b0); push_beat(8'hFF, 1'b0);
    push_beat(8'h42, 1'b0); push_beat(8'h86, 1'b0); push_beat(8'h80, 1'b0);
    push_beat(8'h86, 1'b0);
    // five-octet ID whose low 32 bits equal the expected ID
    push_beat(8'h08, 1'b0); push_beat(8'h00, 1'b0); push_beat(8'h00, 1'b0);
    push_beat(8'h42, 1'b0); push_beat(8'h86, 1'b0);
    push_beat(8'h42, 1'b0);
    push_beat(8'h42, 1'b1); push_beat(8'h86, 1'b0); push_beat(8'h82, 1'b0);
    push_beat(8'h80, 1'b0); push_beat(8'h00, 1'b0);
    close_phase();

    configure(32'(vint_code($urandom_range(1, 4), {$urandom, $urandom})), 1'b0, 1'b0);
    queue_stream(180);
    close_phase();

    send_idle_pct = 55;
    recv_idle_pct = 33;
    configure(32'hFFFF_FFFF, 1'b1, 1'b1);
    queue_stream(180);
    close_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(32'h1A45_DFA3, 1'b0, 1'b0);
    queue_stream(130);
    @(posedge clk_i);
    reader_paused <= 1'b1;
    repeat (100) @(posedge clk_i);
    reader_paused <= 1'b0;
    close_phase();

    configure(32'h0000_0000, 1'b0, 1'b0);
    queue_stream(40);
    close_phase();

    repeat (10) @(posedge clk_i);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("** ebml_integer_element_parser_unit: PASSED **");
    end else begin
      $display("** ebml_integer_element_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
